>>> sv/ssnf_pkg.sv
// shared types, constants and helpers for the seven-segment number formatter
`default_nettype none

package ssnf_pkg;

    // display geometry
    localparam int DIGITS   = 4;
    localparam int NUM_NIBS = 5;
    localparam int NIB_W    = 4 * NUM_NIBS;

    // segment patterns
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_ZERO  = 8'h3F;
    localparam logic [7:0] SEG_DASH  = 8'h40;
    localparam int         COLON_BIT = 15;

    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    // controller command bytes
    localparam logic [15:0] ADDR_MODE = 16'hC040;
    localparam logic [7:0]  CTRL_BASE = 8'h88;
    localparam logic [7:0]  CTRL_OFF  = 8'h80;

    localparam logic [2:0] BRIGHT_RESET = 3'd7;
    localparam logic [1:0] LAST_WORD    = 2'd2;

    typedef enum logic [2:0] {
        FUNC_FULL      = 3'd0,
        FUNC_LEFT      = 3'd1,
        FUNC_RIGHT     = 3'd2,
        FUNC_COLON_ON  = 3'd3,
        FUNC_COLON_OFF = 3'd4,
        FUNC_REFRESH   = 3'd5,
        FUNC_CLEAR     = 3'd6,
        FUNC_UNUSED    = 3'd7
    } func_t;

    // one command with its digits, least significant digit in the bottom nibble position
    typedef struct packed {
        func_t             func;
        logic              pad;
        logic              neg;
        logic [NIB_W-1:0]  nibbles;
    } digit_item_t;

    // the three controller words of one command
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
    } frame_t;

    // one double-dabble step: add 3 to digits of 5 or more, then shift in a bit
    function automatic logic [NIB_W-1:0] dabble_step(input logic [NIB_W-1:0] bcd,
                                                     input logic             b);
        logic [NIB_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < NUM_NIBS; k++) begin
            if (adj[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[NIB_W-2:0], b};
    endfunction

endpackage

`default_nettype wire

>>> sv/seven_segment_number_formatter_top.sv
// top level of the four-digit seven-segment number formatter
`default_nettype none

// Formats commands for a four-digit seven-segment display controller. Each
// accepted item (full signed number, left or right digit pair, colon on/off,
// refresh or clear) yields three 32-bit controller words on the m_ channel,
// the third flagged by m_last; func code 7 is accepted and dropped. Numbers
// go out in decimal or hex, right-aligned, with optional leading zeros, a
// dash for negatives and the leading digits kept on overflow. An item moves
// through an input register and two conversion stages (16 double-dabble
// steps, eight per stage), then updates the segment image as its frame is
// loaded into the output register, which raises m_valid. The output
// sequencer sends one word per cycle while m_ready is high and loads the
// next frame as the last word is taken; up to four items are in flight and
// s_ready stays high while the stages ahead can move. brightness (reset 7)
// is written through cfg_valid/cfg_brightness, always ready, and is used by
// the next frame built.

module seven_segment_number_formatter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_brightness,
    // command items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [15:0] s_value,
    input  wire logic        s_hex_mode,
    input  wire logic        s_pad_zeros,
    // controller words
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_word,
    output logic             m_last
);
    import ssnf_pkg::*;

    // brightness register, added to the display control byte
    logic [2:0] brightness_reg, brightness_next;

    // digit pipeline to image update
    logic        dig_valid, dig_ready;
    digit_item_t dig_item;

    // image update to output sequencer
    logic   load_valid, load_ready;
    frame_t frame;

    assign cfg_ready       = 1'b1;
    assign brightness_next = cfg_valid ? cfg_brightness : brightness_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_RESET;
        end else begin
            brightness_reg <= brightness_next;
        end
    end

    // input register plus binary to digit conversion
    ssnf_digit_pipe u_digit_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_func      (s_func),
        .in_value     (s_value),
        .in_hex_mode  (s_hex_mode),
        .in_pad_zeros (s_pad_zeros),
        .out_valid    (dig_valid),
        .out_ready    (dig_ready),
        .out_item     (dig_item)
    );

    // segment image and colon state, builds the three words
    ssnf_image u_image (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (dig_valid),
        .item_ready (dig_ready),
        .item       (dig_item),
        .brightness (brightness_reg),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .frame      (frame)
    );

    // output register, one word per cycle while m_ready is high
    ssnf_frame_tx u_frame_tx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .frame      (frame),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_word (m_out_word),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

>>> sv/ssnf_digit_pipe.sv
// input register and two-stage binary to digit conversion
`default_nettype none

module ssnf_digit_pipe (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           in_func,
    input  wire logic [15:0]          in_value,
    input  wire logic                 in_hex_mode,
    input  wire logic                 in_pad_zeros,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ssnf_pkg::digit_item_t     out_item
);
    import ssnf_pkg::*;

    // stage 0: input register
    logic        v0_reg;
    func_t       func0_reg;
    logic [15:0] value0_reg;
    logic        hex0_reg;
    logic        pad0_reg;

    // stage 1: upper byte converted
    logic        v1_reg;
    func_t       func1_reg;
    logic        hex1_reg;
    logic        pad1_reg;
    logic        neg1_reg;
    logic [15:0] num1_reg;
    logic [11:0] bcd1_reg;

    // stage 2: all digits
    logic        v2_reg;
    digit_item_t item2_reg;

    logic        rdy0, rdy1, rdy2;
    logic        func_ok;
    logic        neg1_next;
    logic [15:0] num1_next;
    logic [11:0] bcd1_next;
    digit_item_t item2_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;
    assign func_ok  = (func_t'(in_func) != FUNC_UNUSED);

    // magnitude and first eight conversion steps
    always_comb begin
        logic [NIB_W-1:0] b;
        neg1_next = (func0_reg == FUNC_FULL) && value0_reg[15];
        num1_next = neg1_next ? 16'(~value0_reg + 16'd1) : value0_reg;
        b = '0;
        for (int i = 15; i >= 8; i--) begin
            b = dabble_step(b, num1_next[i]);
        end
        bcd1_next = b[11:0];
    end

    // last eight steps, then pick decimal or hex digits
    always_comb begin
        logic [NIB_W-1:0] b;
        b = {8'h00, bcd1_reg};
        for (int i = 7; i >= 0; i--) begin
            b = dabble_step(b, num1_reg[i]);
        end
        item2_next.func    = func1_reg;
        item2_next.pad     = pad1_reg;
        item2_next.neg     = neg1_reg;
        item2_next.nibbles = hex1_reg ? {4'h0, num1_reg} : b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy0) begin
                v0_reg <= in_valid && func_ok;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            func0_reg  <= func_t'(in_func);
            value0_reg <= in_value;
            hex0_reg   <= in_hex_mode;
            pad0_reg   <= in_pad_zeros;
        end
        if (rdy1) begin
            func1_reg <= func0_reg;
            hex1_reg  <= hex0_reg;
            pad1_reg  <= pad0_reg;
            neg1_reg  <= neg1_next;
            num1_reg  <= num1_next;
            bcd1_reg  <= bcd1_next;
        end
        if (rdy2) begin
            item2_reg <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

    // partial decimal digits of the upper byte stay in range
    a_bcd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (bcd1_reg[3:0] <= 4'd9) && (bcd1_reg[7:4] <= 4'd9) &&
                   (bcd1_reg[11:8] <= 4'd2))
        else $error("upper byte digits out of range");

endmodule

`default_nettype wire

>>> sv/ssnf_image.sv
// segment image update, colon state and frame word build
`default_nettype none

module ssnf_image (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire ssnf_pkg::digit_item_t item,
    input  wire logic [2:0]            brightness,
    output logic                       load_valid,
    input  wire logic                  load_ready,
    output ssnf_pkg::frame_t           frame
);
    import ssnf_pkg::*;

    logic [31:0] shown_reg, shown_next;
    logic        colon_reg, colon_next;

    logic             fire;
    logic [2:0]       ndig;
    logic [NIB_W-1:0] lead;
    logic [3:0]       lead_dig [DIGITS];
    logic [31:0]      full_img;
    logic [15:0]      pair_img;
    logic [31:0]      img;

    assign item_ready = load_ready;
    assign load_valid = item_valid;
    assign fire       = item_valid && load_ready;

    // digit count and leading-digit alignment
    always_comb begin
        if (item.nibbles[19:16] != 4'h0) begin
            ndig = 3'd5;
        end else if (item.nibbles[15:12] != 4'h0) begin
            ndig = 3'd4;
        end else if (item.nibbles[11:8] != 4'h0) begin
            ndig = 3'd3;
        end else if (item.nibbles[7:4] != 4'h0) begin
            ndig = 3'd2;
        end else begin
            ndig = 3'd1;
        end
        case (ndig)
            3'd5:    lead = item.nibbles;
            3'd4:    lead = item.nibbles << 4;
            3'd3:    lead = item.nibbles << 8;
            3'd2:    lead = item.nibbles << 12;
            default: lead = item.nibbles << 16;
        endcase
        for (int j = 0; j < DIGITS; j++) begin
            lead_dig[j] = lead[NIB_W-1-4*j -: 4];
        end
    end

    // full number image
    always_comb begin
        logic [2:0] w;
        logic [2:0] off;
        logic [2:0] pos;
        logic [1:0] idx;
        logic [7:0] dig_seg;
        logic [7:0] byte_v;
        if (item.neg) begin
            w   = (ndig > 3'd3) ? 3'd3 : ndig;
            off = 3'd3 - w;
        end else begin
            w   = (ndig > 3'd4) ? 3'd4 : ndig;
            off = 3'd4 - w;
        end
        full_img = '0;
        for (int p = 0; p < DIGITS; p++) begin
            pos     = 3'(p);
            idx     = 2'(pos - off - {2'b00, item.neg});
            dig_seg = SEG_TABLE[lead_dig[idx]];
            if (!item.neg) begin
                if (pos < off) begin
                    byte_v = item.pad ? SEG_ZERO : SEG_BLANK;
                end else begin
                    byte_v = dig_seg;
                end
            end else if (item.pad) begin
                if (pos == 3'd0) begin
                    byte_v = SEG_DASH;
                end else if (pos <= off) begin
                    byte_v = SEG_ZERO;
                end else begin
                    byte_v = dig_seg;
                end
            end else begin
                if (pos < off) begin
                    byte_v = SEG_BLANK;
                end else if (pos == off) begin
                    byte_v = SEG_DASH;
                end else begin
                    byte_v = dig_seg;
                end
            end
            full_img[8*p +: 8] = byte_v;
        end
    end

    // two-digit half image, single digit right-aligned
    always_comb begin
        if (ndig == 3'd1) begin
            pair_img = {SEG_TABLE[lead_dig[0]], item.pad ? SEG_ZERO : SEG_BLANK};
        end else begin
            pair_img = {SEG_TABLE[lead_dig[1]], SEG_TABLE[lead_dig[0]]};
        end
    end

    // next image and colon per command
    always_comb begin
        img        = shown_reg;
        colon_next = colon_reg;
        case (item.func)
            FUNC_FULL: begin
                img = full_img;
                img[COLON_BIT] = full_img[COLON_BIT] | colon_reg;
            end
            FUNC_LEFT: begin
                img = {shown_reg[31:16], pair_img};
                img[COLON_BIT] = pair_img[COLON_BIT] | colon_reg;
            end
            FUNC_RIGHT: begin
                img = {pair_img, shown_reg[15:0]};
                img[COLON_BIT] = shown_reg[COLON_BIT] | colon_reg;
            end
            FUNC_COLON_ON: begin
                colon_next     = 1'b1;
                img[COLON_BIT] = 1'b1;
            end
            FUNC_COLON_OFF: begin
                colon_next     = 1'b0;
                img[COLON_BIT] = 1'b0;
            end
            default: begin
                img = shown_reg;
            end
        endcase
        if (!fire) begin
            colon_next = colon_reg;
        end
        shown_next = fire ? img : shown_reg;
    end

    // controller words
    always_comb begin
        if (item.func == FUNC_CLEAR) begin
            frame.w0 = {24'h000000, CTRL_OFF};
            frame.w1 = {16'h0000, ADDR_MODE};
            frame.w2 = 32'h00000000;
        end else begin
            frame.w0 = {img[15:0], ADDR_MODE};
            frame.w1 = {img[31:16], 16'h0000};
            frame.w2 = {24'h000000, CTRL_BASE + {5'b00000, brightness}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg <= '0;
            colon_reg <= 1'b0;
        end else begin
            shown_reg <= shown_next;
            colon_reg <= colon_next;
        end
    end

    // a lit colon is always in the stored image
    a_colon_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        colon_reg |-> shown_reg[COLON_BIT])
        else $error("colon lit but missing from image");

endmodule

`default_nettype wire

>>> sv/ssnf_frame_tx.sv
// three-word frame register and output sequencer
`default_nettype none

module ssnf_frame_tx (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load_valid,
    output logic                  load_ready,
    input  wire ssnf_pkg::frame_t frame,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [31:0]           m_out_word,
    output logic                  m_last
);
    import ssnf_pkg::*;

    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    frame_t     frame_reg, frame_next;

    logic take, final_take, load;

    assign take       = busy_reg && m_ready;
    assign final_take = take && (idx_reg == LAST_WORD);
    assign load_ready = !busy_reg || final_take;
    assign load       = load_valid && load_ready;

    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        frame_next = frame_reg;
        if (load) begin
            busy_next  = 1'b1;
            idx_next   = 2'd0;
            frame_next = frame;
        end else if (final_take) begin
            busy_next = 1'b0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    always_comb begin
        case (idx_reg)
            2'd0:    m_out_word = frame_reg.w0;
            2'd1:    m_out_word = frame_reg.w1;
            default: m_out_word = frame_reg.w2;
        endcase
    end

    assign m_valid = busy_reg;
    assign m_last  = (idx_reg == LAST_WORD);

    // words of one frame go out without gaps
    a_frame_contig: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !m_last) |=> m_valid)
        else $error("frame interrupted before last word");

    // nothing follows the last word unless a new frame was loaded
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (final_take && !load_valid) |=> !m_valid)
        else $error("output valid after last word with no frame loaded");

    // word index never runs past the last word
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg != 2'd3))
        else $error("word index past end of frame");

endmodule

`default_nettype wire

>>> verif/ssnf_frame_checker.sv
// checker for the seven-segment formatter: predicts controller words and compares them
`timescale 1ns / 100ps

module ssnf_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_brightness,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [15:0] s_value,
    input  wire logic        s_hex_mode,
    input  wire logic        s_pad_zeros,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_out_word,
    input  wire logic        m_last,
    output int               fail_count,
    output int               pending
);
    import ssnf_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } ctrl_word_t;

    ctrl_word_t  words_due[$];
    logic [31:0] image;
    logic        colon_on;
    logic [2:0]  bright;

    function automatic logic [7:0] glyph(input logic [3:0] nib);
        case (nib)
            4'h0: return 8'h3F;
            4'h1: return 8'h06;
            4'h2: return 8'h5B;
            4'h3: return 8'h4F;
            4'h4: return 8'h66;
            4'h5: return 8'h6D;
            4'h6: return 8'h7D;
            4'h7: return 8'h07;
            4'h8: return 8'h7F;
            4'h9: return 8'h6F;
            4'hA: return 8'h77;
            4'hB: return 8'h7C;
            4'hC: return 8'h39;
            4'hD: return 8'h5E;
            4'hE: return 8'h79;
            default: return 8'h71;
        endcase
    endfunction

    // leading digit lands in byte 0, digits past four drop off the top
    function automatic logic [31:0] digit_run(input int unsigned m, input int unsigned base);
        logic [31:0] s;
        logic [3:0]  nib;
        s = '0;
        if (m < base) begin
            nib = 4'(m);
            return {24'd0, glyph(nib)};
        end
        while (m != 0) begin
            nib = 4'(m % base);
            s = {24'd0, glyph(nib)} + (s << 8);
            m = m / base;
        end
        return s;
    endfunction

    function automatic logic [31:0] full_image(input logic [15:0] raw,
                                               input int unsigned base,
                                               input logic pad);
        logic        neg;
        int unsigned mag;
        int unsigned len;
        int unsigned t;
        int unsigned cap;
        int unsigned start;
        logic [31:0] s;
        neg = raw[15];
        mag = neg ? (32'h10000 - raw) : raw;
        len = 0;
        t = mag;
        while (t != 0) begin
            len++;
            t = t / base;
        end
        if (len == 0) len = 1;
        cap = neg ? DIGITS - 1 : DIGITS;
        if (len > cap) len = cap;
        s = digit_run(mag, base);
        start = 0;
        if (pad && len < DIGITS) begin
            if (!neg) begin
                for (int unsigned i = len; i < DIGITS; i++) s = (s << 8) + SEG_ZERO;
            end else begin
                for (int unsigned i = len; i < DIGITS - 1; i++) s = (s << 8) + SEG_ZERO;
                s = (s << 8) + SEG_DASH;
            end
        end else begin
            if (neg) begin
                s = (s << 8) + SEG_DASH;
                len++;
            end
            start = (DIGITS - len) & 3;
        end
        return s << (start * 8);
    endfunction

    // two leading digits, a lone digit gets a blank or zero in front
    function automatic logic [15:0] pair_image(input int unsigned n, input int unsigned base,
                                               input logic pad);
        logic [31:0] s;
        s = digit_run(n, base) & 32'h0000FFFF;
        if (n / base == 0) s = pad ? (SEG_ZERO + (s << 8)) : (s << 8);
        return s[15:0];
    endfunction

    task automatic push_frame(input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2);
        words_due.push_back('{word: w0, last: 1'b0});
        words_due.push_back('{word: w1, last: 1'b0});
        words_due.push_back('{word: w2, last: 1'b1});
    endtask

    task automatic push_image_frame();
        push_frame({image[15:0], ADDR_MODE}, image & 32'hFFFF0000,
                   {24'd0, CTRL_BASE + {5'd0, bright}});
    endtask

    task automatic format_command(input logic [2:0] func, input logic [15:0] value,
                                  input logic hex, input logic pad);
        int unsigned base;
        base = hex ? 16 : 10;
        case (func)
            FUNC_FULL: begin
                image = full_image(value, base, pad);
                if (colon_on) image[COLON_BIT] = 1'b1;
                push_image_frame();
            end
            FUNC_LEFT: begin
                image = (image & 32'hFFFF0000) + {16'd0, pair_image(value, base, pad)};
                if (colon_on) image[COLON_BIT] = 1'b1;
                push_image_frame();
            end
            FUNC_RIGHT: begin
                image = (image & 32'h0000FFFF) + {pair_image(value, base, pad), 16'd0};
                if (colon_on) image[COLON_BIT] = 1'b1;
                push_image_frame();
            end
            FUNC_COLON_ON: begin
                colon_on = 1'b1;
                image[COLON_BIT] = 1'b1;
                push_image_frame();
            end
            FUNC_COLON_OFF: begin
                colon_on = 1'b0;
                image[COLON_BIT] = 1'b0;
                push_image_frame();
            end
            FUNC_REFRESH: push_image_frame();
            FUNC_CLEAR:   push_frame({24'd0, CTRL_OFF}, {16'd0, ADDR_MODE}, 32'd0);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            image = '0;
            colon_on = 1'b0;
            bright = BRIGHT_RESET;
            words_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    report_mismatch("unexpected word", m_out_word, 32'd0);
                end else begin
                    ctrl_word_t want;
                    want = words_due.pop_front();
                    if (m_out_word !== want.word)
                        report_mismatch("out_word", m_out_word, want.word);
                    if (m_last !== want.last)
                        report_mismatch("last", {31'd0, m_last}, {31'd0, want.last});
                end
            end
            if (cfg_valid && cfg_ready) bright = cfg_brightness;
            if (s_valid && s_ready) format_command(s_func, s_value, s_hex_mode, s_pad_zeros);
        end
        pending = words_due.size();
    end

endmodule

>>> verif/seven_segment_number_formatter_top_test.sv
// testbench top for the seven-segment formatter: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module seven_segment_number_formatter_top_test;
    import ssnf_pkg::*;

    // cycles with no handshake at all before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    // pause that covers items still inside the pipeline
    localparam int DRAIN_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 102;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_brightness = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [15:0] s_value = '0;
    logic        s_hex_mode = 1'b0;
    logic        s_pad_zeros = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_word;
    logic        m_last;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    // chance in a hundred per cycle that the sender idles or the receiver stalls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #5 aclk = ~aclk;

    seven_segment_number_formatter_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_brightness(cfg_brightness),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_value       (s_value),
        .s_hex_mode    (s_hex_mode),
        .s_pad_zeros   (s_pad_zeros),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_last        (m_last)
    );

    ssnf_frame_checker frame_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_brightness(cfg_brightness),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_value       (s_value),
        .s_hex_mode    (s_hex_mode),
        .s_pad_zeros   (s_pad_zeros),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: any accepted item on any channel restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one command item, called and returning at a falling edge
    task automatic send_cmd(input logic [2:0] func, input logic [15:0] value,
                            input logic hex, input logic pad);
        // sender gaps before the item, valid low while idle
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_value     <= value;
        s_hex_mode  <= hex;
        s_pad_zeros <= pad;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // wait for every expected word, let dropped items drain, then write brightness
    task automatic write_brightness(input logic [2:0] level);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_brightness <= level;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // numbers weighted toward short digit runs, negatives and the extremes
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 20));
            1: return 16'($urandom_range(0, 9999));
            2: return 16'(32'h10000 - $urandom_range(1, 1100));
            3: begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'h7FFF;
                    2: return 16'h8000;
                    3: return 16'hFFFF;
                    default: return 16'h00FF;
                endcase
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [2:0] pick_func();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r <= 6) return FUNC_FULL;
        if (r <= 9) return FUNC_LEFT;
        if (r <= 12) return FUNC_RIGHT;
        if (r == 13) return FUNC_COLON_ON;
        if (r == 14) return FUNC_COLON_OFF;
        if (r == 15) return FUNC_REFRESH;
        if (r == 16) return FUNC_CLEAR;
        if (r == 17) return FUNC_UNUSED;
        return FUNC_FULL;
    endfunction

    // per phase: sender idle, receiver stall and brightness level
    int          idle_plan  [4] = '{0, 54, 0, 37};
    int          stall_plan [4] = '{0, 0, 54, 37};
    logic [2:0]  level_plan [4] = '{3'd0, 3'd7, 3'd3, 3'd5};

    initial begin
        int          sent;
        logic [2:0]  func;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset brightness, no idling
        send_cmd(FUNC_FULL, 16'd0, 1'b0, 1'b0);        // zero is one digit
        send_cmd(FUNC_FULL, 16'd0, 1'b1, 1'b1);        // zero padded
        send_cmd(FUNC_FULL, 16'h7FFF, 1'b0, 1'b0);     // five digits, leading kept
        send_cmd(FUNC_FULL, 16'h8000, 1'b0, 1'b0);     // most negative
        send_cmd(FUNC_FULL, 16'h8000, 1'b1, 1'b1);
        send_cmd(FUNC_FULL, 16'hFFFF, 1'b0, 1'b1);     // minus one padded, dash leftmost
        send_cmd(FUNC_FULL, 16'hFFFB, 1'b0, 1'b0);     // minus five right-aligned
        send_cmd(FUNC_FULL, 16'd1234, 1'b0, 1'b1);
        send_cmd(FUNC_FULL, 16'd5, 1'b0, 1'b1);
        send_cmd(FUNC_FULL, 16'hBEEF, 1'b1, 1'b0);     // negative in hex
        send_cmd(FUNC_FULL, 16'h1234, 1'b1, 1'b0);
        send_cmd(FUNC_COLON_ON, 16'hFFFF, 1'b1, 1'b1);
        send_cmd(FUNC_FULL, 16'd42, 1'b0, 1'b0);       // colon kept on a new number
        send_cmd(FUNC_LEFT, 16'd7, 1'b0, 1'b0);        // lone digit, blank before
        send_cmd(FUNC_LEFT, 16'd7, 1'b0, 1'b1);        // lone digit, zero before
        send_cmd(FUNC_RIGHT, 16'd99, 1'b0, 1'b0);
        send_cmd(FUNC_RIGHT, 16'hFFFF, 1'b1, 1'b0);    // pair keeps the leading two
        send_cmd(FUNC_LEFT, 16'hFFFF, 1'b0, 1'b1);
        send_cmd(FUNC_RIGHT, 16'd0, 1'b0, 1'b0);
        send_cmd(FUNC_LEFT, 16'd0, 1'b1, 1'b1);
        send_cmd(FUNC_COLON_OFF, 16'd0, 1'b0, 1'b0);
        send_cmd(FUNC_REFRESH, 16'h5A5A, 1'b1, 1'b0);
        send_cmd(FUNC_UNUSED, 16'hFFFF, 1'b1, 1'b1);   // dropped, no words
        send_cmd(FUNC_CLEAR, 16'hFFFF, 1'b1, 1'b1);    // image untouched
        send_cmd(FUNC_REFRESH, 16'd0, 1'b0, 1'b0);

        // random phases, each with its own idling profile and brightness
        for (int p = 0; p < 4; p++) begin
            write_brightness(level_plan[p]);
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                func = pick_func();
                send_cmd(func, pick_value(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                if (func != FUNC_UNUSED) sent++;
            end
        end

        // a last random brightness, then a few refreshes to show it
        write_brightness(3'($urandom_range(0, 7)));
        repeat (4) send_cmd(FUNC_REFRESH, pick_value(), 1'b0, 1'b0);

        // drain everything expected, then give stray words a chance to show up
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
